### rtl/core/dsu_pkg.sv
// ----------------------------------------------------------------------------
// dsu_pkg
// Shared constants and controller/datapath interface types for the
// disjoint-set union-find block.
// ----------------------------------------------------------------------------
package dsu_pkg;

    localparam int DEFAULT_MAX_ELEMS = 1024;

    localparam int ELEM_W  = 10;
    localparam int COUNT_W = 11;
    localparam int RANK_W  = 4;
    localparam int DATA_W  = 32;
    localparam int ADDR_W  = 3;

    localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1024;
    localparam logic [RANK_W-1:0]  RANK_MAX    = 4'd15;

    localparam logic REG_ELEMENT_COUNT = 1'b0;

    localparam logic FUNC_UNITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef struct packed {
        logic load;
        logic rd;
        logic step;
        logic root_cap;
        logic cur_b;
        logic comp_wr;
        logic link1;
        logic link2;
        logic clr_start;
        logic clr_wr;
        logic side;
    } dsu_cmd_t;

    typedef struct packed {
        logic idx_err;
        logic is_root;
        logic at_top;
        logic do_link;
        logic need_bump;
        logic clr_last;
    } dsu_sts_t;

endpackage

### rtl/core/disjoint_set_union_find.sv
// sequence: an index error goes from idle straight to the result strobe; otherwise
//   a root walk with path compression for elem_a, then one for elem_b, then up to two
//   link writes (unite only, roots differing) before the result strobe
// requests: one at a time, taken only in idle; the memory has one read and one write port
// reset: a clearing pass over all MAX_ELEMS entries runs after reset and after every
//   element_count write, with busy high; results strobe done for one cycle
// ----------------------------------------------------------------------------
// disjoint_set_union_find
// Union-find store with union by rank and full path compression.
// ----------------------------------------------------------------------------
module disjoint_set_union_find #(
    parameter int MAX_ELEMS = dsu_pkg::DEFAULT_MAX_ELEMS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          func,
    input  logic [dsu_pkg::ELEM_W-1:0]    elem_a,
    input  logic [dsu_pkg::ELEM_W-1:0]    elem_b,
    output logic                          done,
    output logic                          same_set,
    output logic                          index_error,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dsu_pkg::ADDR_W-1:0]    paddr,
    input  logic [dsu_pkg::DATA_W-1:0]    pwdata,
    output logic [dsu_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);

    dsu_pkg::dsu_cmd_t            cmd;
    dsu_pkg::dsu_sts_t            sts;
    logic [dsu_pkg::COUNT_W-1:0]  element_count;
    logic                         cfg_wr;

    dsu_cfg u_cfg (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .element_count (element_count),
        .cfg_wr        (cfg_wr)
    );

    dsu_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .cfg_wr (cfg_wr),
        .sts    (sts),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    dsu_dp #(
        .MAX_ELEMS (MAX_ELEMS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .func          (func),
        .elem_a        (elem_a),
        .elem_b        (elem_b),
        .element_count (element_count),
        .same_set      (same_set),
        .index_error   (index_error)
    );

endmodule

### rtl/core/dsu_cfg.sv
// ----------------------------------------------------------------------------
// dsu_cfg
// APB register slave holding the element count; flags each count write so
// the store can be reinitialized.
// ----------------------------------------------------------------------------
module dsu_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dsu_pkg::ADDR_W-1:0]    paddr,
    input  logic [dsu_pkg::DATA_W-1:0]    pwdata,
    output logic [dsu_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    output logic [dsu_pkg::COUNT_W-1:0]   element_count,
    output logic                          cfg_wr
);

    logic [dsu_pkg::COUNT_W-1:0] count_reg;
    logic [dsu_pkg::COUNT_W-1:0] count_next;
    logic                        sel_count;

    assign pready    = 1'b1;
    assign sel_count = (paddr[dsu_pkg::ADDR_W-1] == dsu_pkg::REG_ELEMENT_COUNT);
    assign cfg_wr    = psel && penable && pwrite && sel_count;

    always_comb
    begin
        count_next = count_reg;
        if (cfg_wr)
        begin
            count_next = pwdata[dsu_pkg::COUNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= dsu_pkg::COUNT_RESET;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign element_count = count_reg;
    assign prdata = sel_count ?
        {{(dsu_pkg::DATA_W-dsu_pkg::COUNT_W){1'b0}}, count_reg} : '0;

endmodule

### rtl/core/dsu_ctrl.sv
// ----------------------------------------------------------------------------
// dsu_ctrl
// Sequencer for the union-find block: clearing sweep, two root walks with
// path compression, linking by rank and result strobe.
// ----------------------------------------------------------------------------
module dsu_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              cfg_wr,
    input  dsu_pkg::dsu_sts_t sts,
    output dsu_pkg::dsu_cmd_t cmd,
    output logic              busy,
    output logic              done
);

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_CLEAR = 9'b000000010,
        ST_F_RD  = 9'b000000100,
        ST_F_CHK = 9'b000001000,
        ST_C_RD  = 9'b000010000,
        ST_C_WR  = 9'b000100000,
        ST_LINK1 = 9'b001000000,
        ST_LINK2 = 9'b010000000,
        ST_DONE  = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   side_reg;
    logic   side_next;

    always_comb
    begin
        state_next = state_reg;
        side_next  = side_reg;
        cmd        = '0;
        cmd.side   = side_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    side_next  = 1'b0;
                    state_next = sts.idx_err ? ST_DONE : ST_F_RD;
                end
            end
            ST_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_F_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = ST_F_CHK;
            end
            ST_F_CHK:
            begin
                if (sts.is_root)
                begin
                    cmd.root_cap = 1'b1;
                    state_next   = ST_C_RD;
                end
                else
                begin
                    cmd.step   = 1'b1;
                    state_next = ST_F_RD;
                end
            end
            ST_C_RD:
            begin
                if (sts.at_top)
                begin
                    if (!side_reg)
                    begin
                        cmd.cur_b  = 1'b1;
                        side_next  = 1'b1;
                        state_next = ST_F_RD;
                    end
                    else
                    begin
                        state_next = sts.do_link ? ST_LINK1 : ST_DONE;
                    end
                end
                else
                begin
                    cmd.rd     = 1'b1;
                    state_next = ST_C_WR;
                end
            end
            ST_C_WR:
            begin
                cmd.comp_wr = 1'b1;
                state_next  = ST_C_RD;
            end
            ST_LINK1:
            begin
                cmd.link1  = 1'b1;
                state_next = sts.need_bump ? ST_LINK2 : ST_DONE;
            end
            ST_LINK2:
            begin
                cmd.link2  = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (cfg_wr)
        begin
            cmd           = '0;
            cmd.clr_start = 1'b1;
            state_next    = ST_CLEAR;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            side_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            side_reg  <= side_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = (state_reg == ST_DONE);

endmodule

### rtl/core/dsu_dp.sv
// ----------------------------------------------------------------------------
// dsu_dp
// Datapath for the union-find block: parent/rank memory, walk pointers,
// captured roots and ranks, clearing counter and result registers.
// ----------------------------------------------------------------------------
module dsu_dp #(
    parameter int MAX_ELEMS = dsu_pkg::DEFAULT_MAX_ELEMS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  dsu_pkg::dsu_cmd_t             cmd,
    output dsu_pkg::dsu_sts_t             sts,
    input  logic                          func,
    input  logic [dsu_pkg::ELEM_W-1:0]    elem_a,
    input  logic [dsu_pkg::ELEM_W-1:0]    elem_b,
    input  logic [dsu_pkg::COUNT_W-1:0]   element_count,
    output logic                          same_set,
    output logic                          index_error
);

    localparam int AW   = $clog2(MAX_ELEMS);
    localparam int RW   = dsu_pkg::RANK_W;
    localparam int WW   = RW + AW;
    localparam int MW   = $clog2(MAX_ELEMS + 1);
    localparam int LW   = (MW > dsu_pkg::COUNT_W) ? MW : dsu_pkg::COUNT_W;

    logic [WW-1:0] mem [MAX_ELEMS];

    logic [WW-1:0] rdata_reg;
    logic [AW-1:0] cur_reg,  cur_next;
    logic [AW-1:0] x_reg,    x_next;
    logic [AW-1:0] top_reg,  top_next;
    logic [AW-1:0] b_reg,    b_next;
    logic [AW-1:0] ra_reg,   ra_next;
    logic [AW-1:0] rb_reg,   rb_next;
    logic [RW-1:0] rka_reg,  rka_next;
    logic [RW-1:0] rkb_reg,  rkb_next;
    logic          func_reg, func_next;
    logic          err_reg,  err_next;
    logic [AW-1:0] clr_reg,  clr_next;

    logic [LW-1:0] live_n;
    logic [AW-1:0] rd_parent;
    logic [RW-1:0] rd_rank;
    logic          we;
    logic [AW-1:0] waddr;
    logic [WW-1:0] wdata;

    assign live_n = (LW'(element_count) > LW'(MAX_ELEMS)) ?
                    LW'(MAX_ELEMS) : LW'(element_count);

    assign rd_parent = rdata_reg[AW-1:0];
    assign rd_rank   = rdata_reg[WW-1:AW];

    assign sts.idx_err   = (LW'(elem_a) >= live_n) || (LW'(elem_b) >= live_n);
    assign sts.is_root   = (rd_parent == cur_reg);
    assign sts.at_top    = (cur_reg == top_reg);
    assign sts.do_link   = (func_reg == dsu_pkg::FUNC_UNITE) && (ra_reg != rb_reg);
    assign sts.need_bump = (rka_reg == rkb_reg) && (rka_reg != dsu_pkg::RANK_MAX);
    assign sts.clr_last  = (clr_reg == AW'(MAX_ELEMS - 1));

    // write port selection
    always_comb
    begin
        we    = 1'b0;
        waddr = cur_reg;
        wdata = {rd_rank, top_reg};
        if (cmd.clr_wr)
        begin
            we    = 1'b1;
            waddr = clr_reg;
            wdata = {{RW{1'b0}}, clr_reg};
        end
        else if (cmd.comp_wr)
        begin
            we    = 1'b1;
            waddr = cur_reg;
            wdata = {rd_rank, top_reg};
        end
        else if (cmd.link1)
        begin
            we = 1'b1;
            if (rka_reg < rkb_reg)
            begin
                waddr = ra_reg;
                wdata = {rka_reg, rb_reg};
            end
            else
            begin
                waddr = rb_reg;
                wdata = {rkb_reg, ra_reg};
            end
        end
        else if (cmd.link2)
        begin
            we    = 1'b1;
            waddr = ra_reg;
            wdata = {rka_reg + RW'(1), ra_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (cmd.rd)
        begin
            rdata_reg <= mem[cur_reg];
        end
    end

    always_comb
    begin
        cur_next  = cur_reg;
        x_next    = x_reg;
        top_next  = top_reg;
        b_next    = b_reg;
        ra_next   = ra_reg;
        rb_next   = rb_reg;
        rka_next  = rka_reg;
        rkb_next  = rkb_reg;
        func_next = func_reg;
        err_next  = err_reg;
        clr_next  = clr_reg;
        if (cmd.load)
        begin
            func_next = func;
            err_next  = sts.idx_err;
            b_next    = AW'(elem_b);
            cur_next  = AW'(elem_a);
            x_next    = AW'(elem_a);
        end
        if (cmd.step)
        begin
            cur_next = rd_parent;
        end
        if (cmd.root_cap)
        begin
            top_next = cur_reg;
            cur_next = x_reg;
            if (cmd.side)
            begin
                rb_next  = cur_reg;
                rkb_next = rd_rank;
            end
            else
            begin
                ra_next  = cur_reg;
                rka_next = rd_rank;
            end
        end
        if (cmd.cur_b)
        begin
            cur_next = b_reg;
            x_next   = b_reg;
        end
        if (cmd.comp_wr)
        begin
            cur_next = rd_parent;
        end
        if (cmd.clr_start)
        begin
            clr_next = '0;
        end
        else if (cmd.clr_wr)
        begin
            clr_next = clr_reg + AW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
        end
        else
        begin
            clr_reg <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        x_reg    <= x_next;
        top_reg  <= top_next;
        b_reg    <= b_next;
        ra_reg   <= ra_next;
        rb_reg   <= rb_next;
        rka_reg  <= rka_next;
        rkb_reg  <= rkb_next;
        func_reg <= func_next;
        err_reg  <= err_next;
    end

    assign same_set    = !err_reg && (ra_reg == rb_reg);
    assign index_error = err_reg;

endmodule

### rtl/core/dsu_checker.sv
// ----------------------------------------------------------------------------
// dsu_checker
// Port-level checks for the union-find block, bound to the top level.
// ----------------------------------------------------------------------------
module dsu_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       start,
    input logic                       busy,
    input logic                       done,
    input logic                       same_set,
    input logic                       index_error,
    input logic                       psel,
    input logic                       penable,
    input logic                       pwrite,
    input logic [dsu_pkg::ADDR_W-1:0] paddr
);

    logic count_wr;

    assign count_wr = psel && penable && pwrite &&
                      (paddr[dsu_pkg::ADDR_W-1] == dsu_pkg::REG_ELEMENT_COUNT);

    a_done_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held longer than one cycle");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("request taken but block not busy");

    a_done_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result strobe while idle");

    a_error_not_same: assert property (@(posedge clk) disable iff (!rst_n)
        (done && index_error) |-> !same_set)
        else $error("same_set reported with index error");

    a_count_wr_clears: assert property (@(posedge clk) disable iff (!rst_n)
        count_wr |=> (busy && !done))
        else $error("count write did not start clearing");

endmodule

bind disjoint_set_union_find dsu_checker u_dsu_checker (.*);

### verif/tb_disjoint_set_union_find.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_disjoint_set_union_find
// Self-checking bench for the union-find block. A set tracker mirrors the
// parent and rank stores with full path compression and union by rank,
// predicts the same-set and index-error flags of every accepted request,
// and checks each done strobe in order. Several element counts are written
// over the register port, among them zero, one and values past the store
// size, with directed deep trees first and bursty random requests after.
// ----------------------------------------------------------------------------
module tb_disjoint_set_union_find;
    import dsu_pkg::*;

    localparam int MAX_ELEMS  = DEFAULT_MAX_ELEMS;
    localparam int CLK_PERIOD = 20;
    localparam int SETTLE     = 40;
    localparam int PHASE_REQS = 150;

    typedef struct packed {
        logic same_set;
        logic index_error;
    } verdict_t;

    class set_tracker;
        bit [ELEM_W-1:0]  parent [MAX_ELEMS];
        bit [RANK_W-1:0]  rank [MAX_ELEMS];
        bit [COUNT_W-1:0] elem_count;
        verdict_t         expected_verdicts [$];
        int unsigned      mismatches;

        function new();
            mismatches = 0;
            configure(COUNT_RESET);
        endfunction

        function void configure(bit [COUNT_W-1:0] value);
            elem_count = value;
            for (int k = 0; k < MAX_ELEMS; k++)
            begin
                parent[k] = ELEM_W'(k);
                rank[k]   = '0;
            end
        endfunction

        function int unsigned live_count();
            return (elem_count > MAX_ELEMS) ? MAX_ELEMS : elem_count;
        endfunction

        function int unsigned find_root(int unsigned x);
            int unsigned top;
            int unsigned cur;
            int unsigned nxt;
            int unsigned steps;
            top   = x;
            steps = 0;
            while (steps < MAX_ELEMS && parent[top] != top)
            begin
                top = parent[top];
                steps++;
            end
            cur   = x;
            steps = 0;
            while (steps < MAX_ELEMS && cur != top)
            begin
                nxt         = parent[cur];
                parent[cur] = ELEM_W'(top);
                cur         = nxt;
                steps++;
            end
            return top;
        endfunction

        function void note_request(bit f, bit [ELEM_W-1:0] a, bit [ELEM_W-1:0] b);
            verdict_t    v;
            int unsigned n;
            int unsigned ra;
            int unsigned rb;
            n = live_count();
            if (a >= n || b >= n)
            begin
                v.same_set    = 1'b0;
                v.index_error = 1'b1;
            end
            else
            begin
                ra            = find_root(a);
                rb            = find_root(b);
                v.same_set    = (ra == rb);
                v.index_error = 1'b0;
                if (f == FUNC_UNITE && ra != rb)
                begin
                    if (rank[ra] < rank[rb])
                        parent[ra] = ELEM_W'(rb);
                    else
                    begin
                        parent[rb] = ELEM_W'(ra);
                        if (rank[ra] == rank[rb] && rank[ra] < RANK_MAX)
                            rank[ra] = rank[ra] + 1'b1;
                    end
                end
            end
            expected_verdicts.push_back(v);
        endfunction

        function void check_result(logic s, logic e);
            verdict_t want;
            if (expected_verdicts.size() == 0)
            begin
                $error("result without outstanding request: same_set %0b index_error %0b",
                       s, e);
                mismatches++;
                return;
            end
            want = expected_verdicts.pop_front();
            if (s !== want.same_set)
            begin
                $error("same_set: expected %0b, actual %0b", want.same_set, s);
                mismatches++;
            end
            if (e !== want.index_error)
            begin
                $error("index_error: expected %0b, actual %0b", want.index_error, e);
                mismatches++;
            end
        endfunction

        function int unsigned outstanding();
            return expected_verdicts.size();
        endfunction
    endclass

    logic                clk     = 1'b0;
    logic                rst_n   = 1'b0;
    logic                start   = 1'b0;
    logic                func    = FUNC_UNITE;
    logic [ELEM_W-1:0]   elem_a  = '0;
    logic [ELEM_W-1:0]   elem_b  = '0;
    logic                psel    = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite  = 1'b0;
    logic [ADDR_W-1:0]   paddr   = '0;
    logic [DATA_W-1:0]   pwdata  = '0;
    logic                busy;
    logic                done;
    logic                same_set;
    logic                index_error;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    set_tracker  sets = new();
    int unsigned bad_reads = 0;

    disjoint_set_union_find #(
        .MAX_ELEMS(MAX_ELEMS)
    ) DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .func       (func),
        .elem_a     (elem_a),
        .elem_b     (elem_b),
        .done       (done),
        .same_set   (same_set),
        .index_error(index_error),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    initial
    begin
        forever
        begin
            #(CLK_PERIOD / 2) clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
            sets.check_result(same_set, index_error);
    end

    // request held until taken at an edge with busy low
    task automatic issue(bit f, bit [ELEM_W-1:0] a, bit [ELEM_W-1:0] b);
        func   <= f;
        elem_a <= a;
        elem_b <= b;
        start  <= 1'b1;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        sets.note_request(f, a, b);
    endtask

    task automatic rest(int unsigned gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send(bit f, bit [ELEM_W-1:0] a, bit [ELEM_W-1:0] b);
        issue(f, a, b);
        rest($urandom_range(0, 2));
    endtask

    task automatic drain();
        while (sets.outstanding() != 0)
            @(posedge clk);
    endtask

    task automatic write_count(bit [COUNT_W-1:0] value);
        logic [ADDR_W-1:0] addr;
        addr = ADDR_W'(4 * REG_ELEMENT_COUNT);
        rest(1);
        drain();
        repeat (SETTLE) @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (pready !== 1'b1)
            @(posedge clk);
        sets.configure(value);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (pready !== 1'b1)
            @(posedge clk);
        if (prdata[COUNT_W-1:0] !== value)
        begin
            $error("element_count: expected %0d, actual %0d", value, prdata[COUNT_W-1:0]);
            bad_reads++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_requests(int unsigned total, bit dense);
        int unsigned       n;
        int unsigned       left;
        int unsigned       burst;
        int unsigned       gap;
        bit                pause;
        bit                f;
        bit [ELEM_W-1:0]   a;
        bit [ELEM_W-1:0]   b;
        left  = total;
        burst = $urandom_range(1, 16);
        while (left > 0)
        begin
            n = sets.live_count();
            if (n == 0 || $urandom_range(0, 99) < 12)
            begin
                a = ELEM_W'($urandom);
                b = ELEM_W'($urandom);
            end
            else
            begin
                a = ELEM_W'($urandom_range(0, n - 1));
                if ($urandom_range(0, 1))
                    b = ELEM_W'($urandom_range(0, n - 1));
                else
                    b = ELEM_W'((a + $urandom_range(0, 7)) % n);
            end
            f = ($urandom_range(0, 99) < 55) ? FUNC_UNITE : FUNC_QUERY;
            issue(f, a, b);
            left--;
            burst--;
            pause = ($urandom_range(0, 63) == 0);
            gap   = 0;
            if (burst == 0)
            begin
                burst = $urandom_range(1, 16);
                if (!dense)
                    gap = $urandom_range(1, 30);
            end
            if (pause && gap == 0)
                gap = 1;
            rest(gap);
            if (pause)
                drain();
        end
        rest(1);
    endtask

    initial
    begin
        int counts [10];
        counts = '{1, 2, 8, 0, 64, 2047, 1025, 1024, 300, 0};
        counts[9] = $urandom_range(3, 1023);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset count, extremes of the index range
        send(FUNC_QUERY, 10'd0, 10'd1023);
        send(FUNC_UNITE, 10'd1023, 10'd0);
        send(FUNC_QUERY, 10'd0, 10'd1023);
        send(FUNC_UNITE, 10'd0, 10'd1023);
        send(FUNC_QUERY, 10'h2AA, 10'h155);

        // binomial tree over 16 elements for deep paths and rank ties
        write_count(11'd16);
        for (int s = 1; s < 16; s = s * 2)
        begin
            for (int i = 0; i + s < 16; i += 2 * s)
                send(FUNC_UNITE, ELEM_W'(i), ELEM_W'(i + s));
        end
        send(FUNC_QUERY, 10'd15, 10'd0);
        send(FUNC_QUERY, 10'd14, 10'd1);
        send(FUNC_UNITE, 10'd3, 10'd20);
        send(FUNC_QUERY, 10'd16, 10'd0);
        send(FUNC_QUERY, 10'd0, 10'd16);

        for (int p = 0; p < 10; p++)
        begin
            write_count(COUNT_W'(counts[p]));
            random_requests(PHASE_REQS, (p % 4) == 1);
        end

        drain();
        repeat (SETTLE) @(posedge clk);
        if (sets.mismatches == 0 && bad_reads == 0 && sets.outstanding() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
